>>> hw/rtl/ipv4_source_blocklist_filter_top_assert.svh
// Assertion macros shared by the filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef IPV4_SOURCE_BLOCKLIST_FILTER_TOP_ASSERT_SVH
`define IPV4_SOURCE_BLOCKLIST_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Implication or plain property checked on every rising clock edge outside reset.
`define ISBF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("isbf assertion failed");
// Condition that must never be true outside reset.
`define ISBF_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("isbf forbidden condition seen");
`else
`define ISBF_ASSERT(label, clk, rst_n, prop)
`define ISBF_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/isbf_pkg.sv
// Types and constants of the IPv4 source blocklist filter.
// Depends on nothing; imported by every module of the filter.
package isbf_pkg;

  typedef enum logic [1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_DROP    = 2'd1,
    VERDICT_TX_BACK = 2'd2
  } verdict_e;

  // Configuration register indexes.
  localparam logic REG_BLOCKED_ADDR = 1'b0;
  localparam logic REG_SHORT_ACTION = 1'b1;

  localparam int unsigned POS_W = 6;
  localparam int unsigned L3_W  = 5;
  localparam int unsigned CMP_W = 7;

  localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
  localparam logic [L3_W-1:0]  ETH_HDR_LEN  = 5'd14;
  localparam logic [L3_W-1:0]  TAG_LEN      = 5'd4;
  localparam logic [CMP_W-1:0] IPV4_HDR_LEN = 7'd20;
  localparam logic [CMP_W-1:0] SADDR_OFF    = 7'd12;
  localparam logic [CMP_W-1:0] SADDR_END    = 7'd16;

  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_CTAG  = 16'h8100;
  localparam logic [15:0] ETYPE_STAG  = 16'h88A8;

  // Result word handed from the parser to the output register.
  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] source_addr;
  } result_t;

endpackage

>>> hw/rtl/isbf_parser.sv
// Frame header parser: per-frame state and the combinational byte step.
// Depends on isbf_pkg.
module isbf_parser #(
  parameter int unsigned MaxTags = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_frame_i,
  input  logic [31:0]         blocked_addr_i,
  input  logic                short_frame_action_i,
  output isbf_pkg::result_t   result_o
);
  import isbf_pkg::*;

  localparam int unsigned TagW = (MaxTags < 1) ? 1 : $clog2(MaxTags + 1);
  localparam logic [TagW-1:0] TagMax = TagW'(MaxTags);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      etype_q, etype_d;
  logic [L3_W-1:0]  l3_q, l3_d;
  logic [TagW-1:0]  tags_q, tags_d;
  logic [31:0]      addr_q, addr_d;
  logic             ipv4_q, ipv4_d;
  logic             short_q, short_d;

  logic [CMP_W-1:0] pos_p1;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] l3_w;
  logic             is_tag;
  logic [31:0]      src;

  always_comb begin
    pos_w   = CMP_W'(pos_q);
    pos_p1  = pos_w + 7'd1;
    etype_d = {etype_q[7:0], data_byte_i};
    is_tag  = (etype_d == ETYPE_CTAG) || (etype_d == ETYPE_STAG);

    tags_d  = tags_q;
    l3_d    = l3_q;
    short_d = short_q;
    ipv4_d  = ipv4_q;
    if (short_q && (pos_p1 == CMP_W'(l3_q))) begin
      if (is_tag && (tags_q < TagMax)) begin
        tags_d = tags_q + TagW'(1);
        l3_d   = l3_q + TAG_LEN;
      end else begin
        short_d = 1'b0;
        ipv4_d  = (etype_d == ETYPE_IPV4);
      end
    end

    // Source address bytes sit at offsets 12 to 15 of the IPv4 header.
    l3_w   = CMP_W'(l3_d);
    addr_d = addr_q;
    if (!short_d && ipv4_d && (pos_w >= l3_w + SADDR_OFF) && (pos_w < l3_w + SADDR_END)) begin
      addr_d = {addr_q[23:0], data_byte_i};
    end

    src = 32'd0;
    if (!short_d && ipv4_d && (pos_p1 >= l3_w + IPV4_HDR_LEN)) begin
      src = addr_d;
    end
    result_o.source_addr = src;
    if (short_d) begin
      result_o.verdict = short_frame_action_i ? VERDICT_TX_BACK : VERDICT_PASS;
    end else begin
      result_o.verdict = (src == blocked_addr_i) ? VERDICT_DROP : VERDICT_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      etype_q <= '0;
      l3_q    <= ETH_HDR_LEN;
      tags_q  <= '0;
      addr_q  <= '0;
      ipv4_q  <= 1'b0;
      short_q <= 1'b1;
    end else if (step_i) begin
      if (end_of_frame_i) begin
        pos_q   <= '0;
        etype_q <= '0;
        l3_q    <= ETH_HDR_LEN;
        tags_q  <= '0;
        addr_q  <= '0;
        ipv4_q  <= 1'b0;
        short_q <= 1'b1;
      end else begin
        pos_q   <= (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;
        etype_q <= etype_d;
        l3_q    <= l3_d;
        tags_q  <= tags_d;
        addr_q  <= addr_d;
        ipv4_q  <= ipv4_d;
        short_q <= short_d;
      end
    end
  end

endmodule

>>> hw/rtl/isbf_out_reg.sv
// Result register that holds one verdict word until the consumer takes it.
// Depends on isbf_pkg.
module isbf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  isbf_pkg::result_t result_i,
  input  logic              out_stall_i,
  output logic              free_o,
  output logic              out_valid_o,
  output isbf_pkg::result_t result_o
);
  import isbf_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

>>> hw/rtl/ipv4_source_blocklist_filter_top.sv
// Top level of the IPv4 source blocklist filter: input register, register port,
// parser and result register. Depends on isbf_pkg, isbf_parser, isbf_out_reg.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid_i/in_stall_o  data_byte_i, end_of_frame_i
//   output   out        out_valid_o/out_stall_i verdict_o, source_addr_o
//   config   in         psel/penable/pwrite    paddr, pwdata, prdata
//
// One byte word is taken every cycle while in_stall_o is low. A result word is presented
// once the last byte of a frame has passed the input register and its verdict has been
// loaded into the result register. The rate is set by the single parser step between
// the input register and the result register.
// Reset clears the frame state, both configuration registers and the valid flags.
// A stall on the output only backs up the input when a last byte waits for a full
// result register; bytes inside a frame keep flowing.
`include "ipv4_source_blocklist_filter_top_assert.svh"

module ipv4_source_blocklist_filter_top #(
  parameter int unsigned MAX_TAGS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  // Verdict output.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [31:0] source_addr_o,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import isbf_pkg::*;

  // Configuration registers. The register is chosen by the word address bit.
  logic [31:0] blocked_addr_q;
  logic        short_action_q;
  logic        reg_sel;
  logic        reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_addr_q <= '0;
      short_action_q <= 1'b0;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_BLOCKED_ADDR: blocked_addr_q <= pwdata;
        REG_SHORT_ACTION: short_action_q <= pwdata[0];
        default:          blocked_addr_q <= blocked_addr_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCKED_ADDR: prdata = blocked_addr_q;
      REG_SHORT_ACTION: prdata = {31'd0, short_action_q};
      default:          prdata = '0;
    endcase
  end

  // Input register. A held byte steps the parser when it either carries no
  // result or the result register can take the verdict.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eof_q;
  logic       s1_fire;
  logic       out_free;
  logic       in_accept;

  assign s1_fire    = s1_valid_q && (!s1_eof_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_eof_q  <= end_of_frame_i;
    end
  end

  result_t step_result;
  result_t out_result;

  isbf_parser #(
    .MaxTags (MAX_TAGS)
  ) u_parser (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (s1_fire),
    .data_byte_i          (s1_byte_q),
    .end_of_frame_i       (s1_eof_q),
    .blocked_addr_i       (blocked_addr_q),
    .short_frame_action_i (short_action_q),
    .result_o             (step_result)
  );

  isbf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire && s1_eof_q),
    .result_i    (step_result),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign verdict_o     = out_result.verdict;
  assign source_addr_o = out_result.source_addr;

  // An empty input register must never hold off the sender.
  `ISBF_ASSERT(a_no_stall_when_empty, clk_i, rst_ni, !s1_valid_q |-> !in_stall_o)
  // Only the three defined verdict codes leave the block.
  `ISBF_ASSERT_NEVER(a_verdict_code, clk_i, rst_ni, out_valid_o && (verdict_o == 2'd3))
  // A dropped frame carries exactly the blocked address.
  `ISBF_ASSERT(a_drop_matches, clk_i, rst_ni,
    (out_valid_o && (verdict_o == VERDICT_DROP)) |-> (source_addr_o == blocked_addr_q))
  // A frame sent back was cut short, so no address was recorded.
  `ISBF_ASSERT(a_tx_back_no_addr, clk_i, rst_ni,
    (out_valid_o && (verdict_o == VERDICT_TX_BACK)) |-> (source_addr_o == 32'd0))

endmodule
